### rtl/phd_pkg.sv
// shared types, constants and saturating helpers for the projection pipeline
// used by the multiplier, the divider and the top level; depends on nothing
`timescale 1ns / 1ps
package phd_pkg;

  localparam int POSE_WORDS  = 12;
  localparam int COORD_WIDTH = 32;
  localparam int QN = 30;
  localparam int QK = 24;
  localparam int QR = 30;
  localparam int QP = 16;

  // fraction bits plus integer bits of the quotient
  localparam int DIV_STEPS = QN + 32;
  // latency of the multiplier and of the divider
  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = DIV_STEPS + 3;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_PROJECT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEPTH = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [2:0] CFG_FOCAL_X = 3'd0;
  localparam logic [2:0] CFG_FOCAL_Y = 3'd1;
  localparam logic [2:0] CFG_PP      = 3'd2;
  localparam logic [2:0] CFG_K1      = 3'd3;
  localparam logic [2:0] CFG_K2      = 3'd4;
  localparam logic [2:0] CFG_K3      = 3'd5;
  localparam logic [2:0] CFG_P1      = 3'd6;
  localparam logic [2:0] CFG_P2      = 3'd7;

  localparam logic signed [31:0] ROT_ONE  = 32'sh4000_0000;
  localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic sat;
    s64_t val;
  } sval_t;

  typedef struct packed {
    logic                          action;
    logic [3:0]                    pose_index;
    logic signed [31:0]            pose_value;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } phd_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pixel_u;
    logic signed [COORD_WIDTH-1:0] pixel_v;
    logic [1:0]                    status;
  } phd_out_t;

  // magnitude of a signed word as unsigned
  function automatic logic [63:0] mag64(input s64_t a);
    mag64 = a[63] ? (64'd0 - a) : a;
  endfunction

  // saturating add
  function automatic sval_t sadd(input s64_t a, input s64_t b);
    sval_t r;
    s64_t  s;
    s = a + b;
    r.sat = (a[63] == b[63]) && (s[63] != a[63]);
    r.val = r.sat ? (b[63] ? S64_MIN : S64_MAX) : s;
    sadd = r;
  endfunction

endpackage

### rtl/phd_delay.sv
// enabled delay line used to align operands between pipeline stages
// depends on nothing
`timescale 1ns / 1ps
module phd_delay #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] dl_r [DEPTH];

  // shift on every enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  assign dout = dl_r[DEPTH-1];

endmodule

### rtl/phd_smul.sv
// pipelined signed 64x64 multiply, scaled right with magnitude truncation, saturated
// four 32x32 partial products; depends on phd_pkg
`timescale 1ns / 1ps
module phd_smul #(
  parameter int SH = 30
) (
  input  logic          clk,
  input  logic          en,
  input  phd_pkg::s64_t a,
  input  phd_pkg::s64_t b,
  output phd_pkg::sval_t res
);
  import phd_pkg::*;

  logic [63:0]  ua_r, ub_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] full_r;
  sval_t        res_r;

  logic [127:0] full_nxt;
  logic [127:0] shifted;
  logic         sat_nxt;
  logic [63:0]  m_nxt;

  // partial product sum and scaling
  always_comb begin
    full_nxt = {p11_r, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0};
    shifted  = full_r >> SH;
    sat_nxt  = |shifted[127:63];
    m_nxt    = sat_nxt ? 64'(S64_MAX) : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes
      ua_r   <= mag64(a);
      ub_r   <= mag64(b);
      neg1_r <= a[63] ^ b[63];
      // partial products
      p00_r  <= ua_r[31:0]  * ub_r[31:0];
      p01_r  <= ua_r[31:0]  * ub_r[63:32];
      p10_r  <= ua_r[63:32] * ub_r[31:0];
      p11_r  <= ua_r[63:32] * ub_r[63:32];
      neg2_r <= neg1_r;
      // full product
      full_r <= full_nxt;
      neg3_r <= neg2_r;
      // sign and saturation
      res_r.sat <= sat_nxt;
      res_r.val <= neg3_r ? s64_t'(64'd0 - m_nxt) : s64_t'(m_nxt);
    end
  end

  assign res = res_r;

endmodule

### rtl/phd_div.sv
// pipelined restoring divider: num / den in Q.QN, truncated toward zero
// one quotient bit per stage; depends on phd_pkg
`timescale 1ns / 1ps
module phd_div (
  input  logic           clk,
  input  logic           en,
  input  phd_pkg::s64_t  num,
  input  phd_pkg::s64_t  den,
  output phd_pkg::sval_t quo
);
  import phd_pkg::*;

  localparam int NB = DIV_STEPS;

  logic [63:0]   ua_r, ud0_r;
  logic          neg0_r;
  logic [63:0]   rem_r [NB+1];
  logic [NB-1:0] nq_r  [NB+1];
  logic [63:0]   ud_r  [NB+1];
  logic          neg_r [NB+1];
  logic          ovf_r [NB+1];
  sval_t         quo_r;

  logic [63:0] qmag;

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitude of the numerator
      ua_r   <= mag64(num);
      ud0_r  <= den;
      neg0_r <= num[63];
      // integer part overflow check and initial remainder
      rem_r[0] <= {32'd0, ua_r[63:32]};
      nq_r[0]  <= {ua_r[31:0], {(NB-32){1'b0}}};
      ud_r[0]  <= ud0_r;
      neg_r[0] <= neg0_r;
      ovf_r[0] <= ({32'd0, ua_r[63:32]} >= ud0_r);
    end
  end

  // one compare and subtract per stage
  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;
    always_comb begin
      trial = {rem_r[k], nq_r[k][NB-1]};
      diff  = trial - {1'b0, ud_r[k]};
      ge    = !diff[64];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[63:0] : trial[63:0];
        nq_r[k+1]  <= {nq_r[k][NB-2:0], ge};
        ud_r[k+1]  <= ud_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // sign, with saturation when the integer part does not fit
  always_comb begin
    qmag = ovf_r[NB] ? 64'(S64_MAX) : {{(64-NB){1'b0}}, nq_r[NB]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r.sat <= ovf_r[NB];
      quo_r.val <= neg_r[NB] ? s64_t'(64'd0 - qmag) : s64_t'(qmag);
    end
  end

  assign quo = quo_r;

endmodule

### rtl/pinhole_project_with_distortion_unit.sv
// pinhole projection with radial and tangential lens distortion, top level
// throughput: one beat per cycle while the output is not stalled; pose loads give no result
// pipeline depth set by the divider (one quotient bit per stage) and 4-stage multipliers
// reset: identity rotation, zero translation, unit focal lengths, zero coefficients
// depends on phd_pkg, phd_delay, phd_smul, phd_div
`timescale 1ns / 1ps
module pinhole_project_with_distortion_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  phd_pkg::phd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output phd_pkg::phd_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import phd_pkg::*;

  localparam int ML     = MUL_LAT;
  localparam int T_M1   = ML;
  localparam int T_A1   = T_M1 + 1;
  localparam int T_A2   = T_M1 + 2;
  localparam int T_A3   = T_M1 + 3;
  localparam int T_X    = T_A3 + DIV_LAT;
  localparam int T_SQ   = T_X + ML;
  localparam int T_R2   = T_SQ + 1;
  localparam int T_AXY  = T_R2 + 1;
  localparam int T_R4   = T_R2 + ML;
  localparam int T_TM   = T_AXY + ML;
  localparam int T_TXY  = T_TM + 1;
  localparam int T_R6   = T_R4 + ML;
  localparam int T_RAD1 = T_R6 + 1;
  localparam int T_K3   = T_R6 + ML;
  localparam int T_RAD  = T_K3 + 1;
  localparam int T_XR   = T_RAD + ML;
  localparam int T_XS   = T_XR + 1;
  localparam int T_XD   = T_XS + 1;
  localparam int T_UF   = T_XD + ML;
  localparam int T_U    = T_UF + 1;
  localparam int CW     = COORD_WIDTH;

  // configuration registers
  logic [31:0] focal_x_r, focal_y_r;
  logic [63:0] pp_r;
  logic signed [31:0] k1_r, k2_r, k3_r, p1_r, p2_r;
  logic signed [31:0] pose_r [POSE_WORDS];

  logic  en;
  logic  vld_r  [T_U+1];
  logic  satp_r [T_U+1];
  logic [T_U:0] inj;

  s64_t  p_r    [3];
  s64_t  pose_s0_r [POSE_WORDS];

  logic     out_valid_r;
  phd_out_t out_data_r;

  // the pipeline moves unless a finished beat would overrun a waiting output
  assign en       = !vld_r[T_U] || !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= 32'd1 << QP;
      focal_y_r <= 32'd1 << QP;
      pp_r      <= '0;
      k1_r <= '0; k2_r <= '0; k3_r <= '0; p1_r <= '0; p2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL_X: focal_x_r <= cfg_data[31:0];
        CFG_FOCAL_Y: focal_y_r <= cfg_data[31:0];
        CFG_PP:      pp_r      <= cfg_data;
        CFG_K1:      k1_r      <= cfg_data[31:0];
        CFG_K2:      k2_r      <= cfg_data[31:0];
        CFG_K3:      k3_r      <= cfg_data[31:0];
        CFG_P1:      p1_r      <= cfg_data[31:0];
        CFG_P2:      p2_r      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pose store, written by load beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POSE_WORDS; i++) begin
        pose_r[i] <= ((i % 4) == 0 && i < 9) ? ROT_ONE : 32'sd0;
      end
    end else if (in_valid && en && in_data.action == ACT_LOAD
                 && in_data.pose_index < 4'(POSE_WORDS)) begin
      pose_r[in_data.pose_index] <= in_data.pose_value;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= T_U; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid && in_data.action == ACT_PROJECT;
      for (int i = 1; i <= T_U; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // saturation chain, flags join at the stage that raises them
  always_ff @(posedge clk) begin
    if (en) begin
      satp_r[0] <= 1'b0;
      for (int i = 1; i <= T_U; i++) satp_r[i] <= satp_r[i-1] | inj[i-1];
    end
  end

  // entry stage: point and pose snapshot
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= {{(64-CW){in_data.point_x[CW-1]}}, in_data.point_x};
      p_r[1] <= {{(64-CW){in_data.point_y[CW-1]}}, in_data.point_y};
      p_r[2] <= {{(64-CW){in_data.point_z[CW-1]}}, in_data.point_z};
      for (int i = 0; i < POSE_WORDS; i++) begin
        pose_s0_r[i] <= {{32{pose_r[i][31]}}, pose_r[i]};
      end
    end
  end

  // rotation products
  sval_t m_res [9];
  for (genvar g = 0; g < 9; g++) begin : g_rot
    phd_smul #(.SH(QR)) u_mul (
      .clk(clk), .en(en), .a(pose_s0_r[g]), .b(p_r[g % 3]), .res(m_res[g])
    );
  end

  // translation and accumulation, one add per stage in row order
  sval_t acc1_r [3], acc2_r [3], acc3_r [3];
  for (genvar g = 0; g < 3; g++) begin : g_acc
    logic [63:0] t_d, m1_d, m2_d;
    phd_delay #(.WIDTH(64), .DEPTH(ML)) u_dt (
      .clk(clk), .en(en), .din(pose_s0_r[9+g]), .dout(t_d));
    phd_delay #(.WIDTH(64), .DEPTH(1)) u_dm1 (
      .clk(clk), .en(en), .din(m_res[g*3+1].val), .dout(m1_d));
    phd_delay #(.WIDTH(64), .DEPTH(2)) u_dm2 (
      .clk(clk), .en(en), .din(m_res[g*3+2].val), .dout(m2_d));
    always_ff @(posedge clk) begin
      if (en) begin
        acc1_r[g] <= sadd(t_d, m_res[g*3].val);
        acc2_r[g] <= sadd(acc1_r[g].val, m1_d);
        acc3_r[g] <= sadd(acc2_r[g].val, m2_d);
      end
    end
  end

  // depth test travels to the output
  logic depth_bad_u;
  phd_delay #(.WIDTH(1), .DEPTH(T_U - T_A3)) u_ddep (
    .clk(clk), .en(en), .din(acc3_r[2].val <= 64'sd0), .dout(depth_bad_u));

  // perspective divide
  sval_t x_res, y_res;
  phd_div u_divx (.clk(clk), .en(en), .num(acc3_r[0].val), .den(acc3_r[2].val),
                  .quo(x_res));
  phd_div u_divy (.clk(clk), .en(en), .num(acc3_r[1].val), .den(acc3_r[2].val),
                  .quo(y_res));

  // squares and cross term
  sval_t x2_res, y2_res, xy_res;
  phd_smul #(.SH(QN)) u_x2 (.clk(clk), .en(en), .a(x_res.val), .b(x_res.val), .res(x2_res));
  phd_smul #(.SH(QN)) u_y2 (.clk(clk), .en(en), .a(y_res.val), .b(y_res.val), .res(y2_res));
  phd_smul #(.SH(QN)) u_xy (.clk(clk), .en(en), .a(x_res.val), .b(y_res.val), .res(xy_res));

  sval_t r2_r, txy_r, x2x2_r, y2y2_r, ax_r, ay_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r2_r   <= sadd(x2_res.val, y2_res.val);
      txy_r  <= sadd(xy_res.val, xy_res.val);
      x2x2_r <= sadd(x2_res.val, x2_res.val);
      y2y2_r <= sadd(y2_res.val, y2_res.val);
      ax_r   <= sadd(r2_r.val, x2x2_r.val);
      ay_r   <= sadd(r2_r.val, y2y2_r.val);
    end
  end

  s64_t k1_s, k2_s, k3_s, p1_s, p2_s, fx_s, fy_s, cx_s, cy_s;
  assign k1_s = {{32{k1_r[31]}}, k1_r};
  assign k2_s = {{32{k2_r[31]}}, k2_r};
  assign k3_s = {{32{k3_r[31]}}, k3_r};
  assign p1_s = {{32{p1_r[31]}}, p1_r};
  assign p2_s = {{32{p2_r[31]}}, p2_r};
  assign fx_s = {32'd0, focal_x_r};
  assign fy_s = {32'd0, focal_y_r};
  assign cx_s = {32'd0, pp_r[31:0]};
  assign cy_s = {32'd0, pp_r[63:32]};

  // radial powers and first coefficient terms
  sval_t r4_res, k1r2_res, p1txy_res, p2txy_res, p2ax_res, p1ay_res;
  phd_smul #(.SH(QN)) u_r4 (.clk(clk), .en(en), .a(r2_r.val), .b(r2_r.val), .res(r4_res));
  phd_smul #(.SH(QK)) u_k1 (.clk(clk), .en(en), .a(k1_s), .b(r2_r.val), .res(k1r2_res));
  phd_smul #(.SH(QK)) u_p1t (.clk(clk), .en(en), .a(p1_s), .b(txy_r.val), .res(p1txy_res));
  phd_smul #(.SH(QK)) u_p2t (.clk(clk), .en(en), .a(p2_s), .b(txy_r.val), .res(p2txy_res));
  phd_smul #(.SH(QK)) u_p2a (.clk(clk), .en(en), .a(p2_s), .b(ax_r.val), .res(p2ax_res));
  phd_smul #(.SH(QK)) u_p1a (.clk(clk), .en(en), .a(p1_s), .b(ay_r.val), .res(p1ay_res));

  // tangential terms
  logic [63:0] p1txy_d, p2txy_d;
  sval_t tx_r, ty_r;
  phd_delay #(.WIDTH(64), .DEPTH(T_TM - T_R4)) u_dp1t (
    .clk(clk), .en(en), .din(p1txy_res.val), .dout(p1txy_d));
  phd_delay #(.WIDTH(64), .DEPTH(T_TM - T_R4)) u_dp2t (
    .clk(clk), .en(en), .din(p2txy_res.val), .dout(p2txy_d));
  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= sadd(p1txy_d, p2ax_res.val);
      ty_r <= sadd(p1ay_res.val, p2txy_d);
    end
  end

  // sixth power and higher radial terms
  logic [63:0] r2_d, k1r2_d, rad1_d;
  sval_t r6_res, k2r4_res, k3r6_res, rad1_r, rad_r;
  phd_delay #(.WIDTH(64), .DEPTH(T_R4 - T_R2)) u_dr2 (
    .clk(clk), .en(en), .din(r2_r.val), .dout(r2_d));
  phd_smul #(.SH(QN)) u_r6 (.clk(clk), .en(en), .a(r4_res.val), .b(r2_d), .res(r6_res));
  phd_smul #(.SH(QK)) u_k2 (.clk(clk), .en(en), .a(k2_s), .b(r4_res.val), .res(k2r4_res));
  phd_smul #(.SH(QK)) u_k3 (.clk(clk), .en(en), .a(k3_s), .b(r6_res.val), .res(k3r6_res));
  phd_delay #(.WIDTH(64), .DEPTH(T_R6 - T_R4)) u_dk1 (
    .clk(clk), .en(en), .din(k1r2_res.val), .dout(k1r2_d));
  phd_delay #(.WIDTH(64), .DEPTH(T_K3 - T_RAD1)) u_drad1 (
    .clk(clk), .en(en), .din(rad1_r.val), .dout(rad1_d));
  always_ff @(posedge clk) begin
    if (en) begin
      rad1_r <= sadd(k1r2_d, k2r4_res.val);
      rad_r  <= sadd(rad1_d, k3r6_res.val);
    end
  end

  // distorted coordinates
  logic [63:0] x_d, y_d, x_d2, y_d2, tx_d, ty_d;
  sval_t xrad_res, yrad_res, xs_r, ys_r, xd_r, yd_r;
  phd_delay #(.WIDTH(64), .DEPTH(T_RAD - T_X)) u_dx (
    .clk(clk), .en(en), .din(x_res.val), .dout(x_d));
  phd_delay #(.WIDTH(64), .DEPTH(T_RAD - T_X)) u_dy (
    .clk(clk), .en(en), .din(y_res.val), .dout(y_d));
  phd_smul #(.SH(QN)) u_xr (.clk(clk), .en(en), .a(x_d), .b(rad_r.val), .res(xrad_res));
  phd_smul #(.SH(QN)) u_yr (.clk(clk), .en(en), .a(y_d), .b(rad_r.val), .res(yrad_res));
  phd_delay #(.WIDTH(64), .DEPTH(T_XR - T_RAD)) u_dx2 (
    .clk(clk), .en(en), .din(x_d), .dout(x_d2));
  phd_delay #(.WIDTH(64), .DEPTH(T_XR - T_RAD)) u_dy2 (
    .clk(clk), .en(en), .din(y_d), .dout(y_d2));
  phd_delay #(.WIDTH(64), .DEPTH(T_XS - T_TXY)) u_dtx (
    .clk(clk), .en(en), .din(tx_r.val), .dout(tx_d));
  phd_delay #(.WIDTH(64), .DEPTH(T_XS - T_TXY)) u_dty (
    .clk(clk), .en(en), .din(ty_r.val), .dout(ty_d));
  always_ff @(posedge clk) begin
    if (en) begin
      xs_r <= sadd(x_d2, xrad_res.val);
      ys_r <= sadd(y_d2, yrad_res.val);
      xd_r <= sadd(xs_r.val, tx_d);
      yd_r <= sadd(ys_r.val, ty_d);
    end
  end

  // focal scaling and principal point
  sval_t uf_res, vf_res, u_r, v_r;
  phd_smul #(.SH(QN)) u_fx (.clk(clk), .en(en), .a(fx_s), .b(xd_r.val), .res(uf_res));
  phd_smul #(.SH(QN)) u_fy (.clk(clk), .en(en), .a(fy_s), .b(yd_r.val), .res(vf_res));
  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= sadd(uf_res.val, cx_s);
      v_r <= sadd(vf_res.val, cy_s);
    end
  end

  // saturation flags by stage
  always_comb begin
    inj = '0;
    for (int i = 0; i < 9; i++) inj[T_M1] = inj[T_M1] | m_res[i].sat;
    for (int i = 0; i < 3; i++) begin
      inj[T_A1] = inj[T_A1] | acc1_r[i].sat;
      inj[T_A2] = inj[T_A2] | acc2_r[i].sat;
      inj[T_A3] = inj[T_A3] | acc3_r[i].sat;
    end
    inj[T_X]    = inj[T_X]    | x_res.sat | y_res.sat;
    inj[T_SQ]   = inj[T_SQ]   | x2_res.sat | y2_res.sat | xy_res.sat;
    inj[T_R2]   = inj[T_R2]   | r2_r.sat | txy_r.sat | x2x2_r.sat | y2y2_r.sat;
    inj[T_AXY]  = inj[T_AXY]  | ax_r.sat | ay_r.sat;
    inj[T_R4]   = inj[T_R4]   | r4_res.sat | k1r2_res.sat | p1txy_res.sat | p2txy_res.sat;
    inj[T_TM]   = inj[T_TM]   | p2ax_res.sat | p1ay_res.sat;
    inj[T_TXY]  = inj[T_TXY]  | tx_r.sat | ty_r.sat;
    inj[T_R6]   = inj[T_R6]   | r6_res.sat | k2r4_res.sat;
    inj[T_RAD1] = inj[T_RAD1] | rad1_r.sat;
    inj[T_K3]   = inj[T_K3]   | k3r6_res.sat;
    inj[T_RAD]  = inj[T_RAD]  | rad_r.sat;
    inj[T_XR]   = inj[T_XR]   | xrad_res.sat | yrad_res.sat;
    inj[T_XS]   = inj[T_XS]   | xs_r.sat | ys_r.sat;
    inj[T_XD]   = inj[T_XD]   | xd_r.sat | yd_r.sat;
    inj[T_UF]   = inj[T_UF]   | uf_res.sat | vf_res.sat;
    inj[T_U]    = inj[T_U]    | u_r.sat | v_r.sat;
  end

  // clamp to the pixel range and pick the status
  logic u_fit, v_fit, sat_all;
  phd_out_t res_nxt;
  always_comb begin
    u_fit   = (u_r.val[63:CW-1] == '0) || (u_r.val[63:CW-1] == '1);
    v_fit   = (v_r.val[63:CW-1] == '0) || (v_r.val[63:CW-1] == '1);
    sat_all = satp_r[T_U] | inj[T_U] | !u_fit | !v_fit;
    if (depth_bad_u) begin
      res_nxt.pixel_u = '0;
      res_nxt.pixel_v = '0;
      res_nxt.status  = ST_DEPTH;
    end else begin
      res_nxt.pixel_u = u_fit ? u_r.val[CW-1:0] : {u_r.val[63], {(CW-1){!u_r.val[63]}}};
      res_nxt.pixel_v = v_fit ? v_r.val[CW-1:0] : {v_r.val[63], {(CW-1){!v_r.val[63]}}};
      res_nxt.status  = sat_all ? ST_SAT : ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vld_r[T_U]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[T_U]) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
